FILE: rtl/lmrr_pkg.sv
// ----------------------------------------------------------------------------
// Lock manager package
// Shared sizes, codes and word types for the revoke/retry lock directory.
// ----------------------------------------------------------------------------
package lmrr_pkg;

  localparam int NUM_LOCKS   = 256;
  localparam int NUM_CLIENTS = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int CLIENT_W  = 4;
  localparam int LOCK_ID_W = 8;
  localparam int LOCK_W    = $clog2(NUM_LOCKS);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [1:0] RPL_OK    = 2'd0;
  localparam logic [1:0] RPL_RETRY = 2'd1;
  localparam logic [1:0] RPL_FULL  = 2'd2;

  localparam logic [1:0] MODE_LOCKED   = 2'd0;
  localparam logic [1:0] MODE_REVOKING = 2'd1;
  localparam logic [1:0] MODE_RETRYING = 2'd2;

  typedef struct packed {
    logic                 req_type;
    logic [CLIENT_W-1:0]  client_id;
    logic [LOCK_ID_W-1:0] lock_id;
  } req_t;

  typedef struct packed {
    logic [1:0]          reply;
    logic                send_revoke;
    logic [CLIENT_W-1:0] revoke_target;
    logic                send_retry;
    logic [CLIENT_W-1:0] retry_target;
  } rsp_t;

  // Per-lock record held in the metadata table.
  typedef struct packed {
    logic [1:0]          mode;
    logic [CLIENT_W-1:0] holder;
    logic                next_valid;
    logic [CLIENT_W-1:0] next_client;
    logic [CNT_W-1:0]    count;
  } lock_meta_t;

  // Waiting clients of one lock, oldest in element 0.
  typedef logic [QUEUE_DEPTH-1:0][CLIENT_W-1:0] queue_row_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

FILE: rtl/lmrr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lmrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/lmrr_ctrl.sv
// ----------------------------------------------------------------------------
// Lock manager controller
// Sequences one request through table read and write-back, and owns the
// result word's valid flag.
// ----------------------------------------------------------------------------
module lmrr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lmrr_pkg::ctrl_cmd_t cmd
);

  import lmrr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state_r == ST_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A request must not leave the execute step while the result slot is taken.
  a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !out_free) |=> (state_r == ST_EXEC))
    else $error("request left execute with the result slot occupied");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC && !in_ready))
    else $error("accepted request did not move to execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

FILE: rtl/lmrr_datapath.sv
// ----------------------------------------------------------------------------
// Lock manager datapath
// Lock tables, waiter queues, the decision logic and the result register.
// ----------------------------------------------------------------------------
module lmrr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lmrr_pkg::ctrl_cmd_t cmd,
  input  lmrr_pkg::req_t      in_data,
  output lmrr_pkg::rsp_t      out_data
);

  import lmrr_pkg::*;

  localparam int META_W  = $bits(lock_meta_t);
  localparam int QUEUE_W = $bits(queue_row_t);

  req_t                 req_r;
  rsp_t                 out_data_r;
  rsp_t                 rsp;
  logic [NUM_LOCKS-1:0] entry_used_r;
  logic [META_W-1:0]    meta_rd_bits;
  logic [QUEUE_W-1:0]   queue_rd_bits;
  lock_meta_t           meta_q;
  lock_meta_t           meta_nxt;
  queue_row_t           queue_q;
  queue_row_t           queue_nxt;
  queue_row_t           queue_push;
  queue_row_t           queue_pop;
  logic [LOCK_W-1:0]    lk;
  logic [CLIENT_W-1:0]  c;
  logic                 used;
  logic                 known_wait;
  logic                 is_next;
  logic                 known;
  logic                 full;
  logic                 in_range;
  logic                 meta_we;
  logic                 queue_we;
  logic                 used_we;
  logic                 used_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_data_r <= rsp;
    end
  end

  lmrr_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_LOCKS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (lk),
    .wr_data (meta_nxt),
    .rd_en   (cmd.capture),
    .rd_addr (in_data.lock_id[LOCK_W-1:0]),
    .rd_data (meta_rd_bits)
  );

  lmrr_ram #(
    .WIDTH (QUEUE_W),
    .DEPTH (NUM_LOCKS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (queue_we),
    .wr_addr (lk),
    .wr_data (queue_nxt),
    .rd_en   (cmd.capture),
    .rd_addr (in_data.lock_id[LOCK_W-1:0]),
    .rd_data (queue_rd_bits)
  );

  assign meta_q  = lock_meta_t'(meta_rd_bits);
  assign queue_q = queue_row_t'(queue_rd_bits);
  assign lk      = req_r.lock_id[LOCK_W-1:0];
  assign c       = req_r.client_id;
  assign used    = entry_used_r[lk];

  // Queue matching, append and pop over the fixed slots of one row.
  always_comb begin
    known_wait = 1'b0;
    queue_push = queue_q;
    queue_pop  = queue_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i < int'(meta_q.count) && queue_q[i] == c) begin
        known_wait = 1'b1;
      end
      if (i == int'(meta_q.count)) begin
        queue_push[i] = c;
      end
      if (i + 1 < QUEUE_DEPTH) begin
        queue_pop[i] = queue_q[i+1];
      end
    end
  end

  assign is_next  = meta_q.next_valid && (meta_q.next_client == c);
  assign known    = known_wait || is_next;
  assign full     = (meta_q.count >= CNT_W'(QUEUE_DEPTH));
  assign in_range = ({1'b0, c} < (CLIENT_W + 1)'(NUM_CLIENTS));

  always_comb begin
    rsp       = '0;
    meta_nxt  = meta_q;
    queue_nxt = queue_q;
    meta_we   = 1'b0;
    queue_we  = 1'b0;
    used_we   = 1'b0;
    used_val  = 1'b0;
    priority if (!in_range) begin
      rsp.reply = RPL_RETRY;
    end else if (req_r.req_type == REQ_RELEASE) begin
      rsp.reply = RPL_OK;
      if (used && meta_q.holder == c) begin
        if (meta_q.count != '0) begin
          // Hand the lock to the oldest waiter and ask it to resend.
          queue_nxt            = queue_pop;
          queue_we             = 1'b1;
          meta_nxt.mode        = MODE_RETRYING;
          meta_nxt.next_valid  = 1'b1;
          meta_nxt.next_client = queue_q[0];
          meta_nxt.count       = meta_q.count - CNT_W'(1);
          meta_we              = 1'b1;
          rsp.send_retry       = 1'b1;
          rsp.retry_target     = queue_q[0];
        end else begin
          used_we = 1'b1;
        end
      end
    end else if (!used) begin
      rsp.reply            = RPL_OK;
      used_we              = 1'b1;
      used_val             = 1'b1;
      meta_nxt.mode        = MODE_LOCKED;
      meta_nxt.holder      = c;
      meta_nxt.next_valid  = 1'b0;
      meta_nxt.next_client = '0;
      meta_nxt.count       = '0;
      meta_we              = 1'b1;
    end else if (meta_q.mode == MODE_LOCKED || meta_q.mode == MODE_REVOKING) begin
      if (meta_q.holder == c) begin
        rsp.reply = RPL_OK;
      end else if (known) begin
        rsp.reply         = RPL_RETRY;
        rsp.send_revoke   = 1'b1;
        rsp.revoke_target = meta_q.holder;
      end else if (full) begin
        rsp.reply = RPL_FULL;
      end else begin
        rsp.reply      = RPL_RETRY;
        queue_nxt      = queue_push;
        queue_we       = 1'b1;
        meta_nxt.count = meta_q.count + CNT_W'(1);
        meta_we        = 1'b1;
        if (meta_q.mode == MODE_LOCKED) begin
          meta_nxt.mode     = MODE_REVOKING;
          rsp.send_revoke   = 1'b1;
          rsp.revoke_target = meta_q.holder;
        end
      end
    end else if (meta_q.mode == MODE_RETRYING) begin
      if (is_next) begin
        // The chosen client takes over; the choice itself is left standing.
        rsp.reply       = RPL_OK;
        meta_nxt.holder = c;
        meta_we         = 1'b1;
        if (meta_q.count != '0) begin
          meta_nxt.mode     = MODE_REVOKING;
          rsp.send_revoke   = 1'b1;
          rsp.revoke_target = c;
        end else begin
          meta_nxt.mode = MODE_LOCKED;
        end
      end else if (known) begin
        rsp.reply = RPL_RETRY;
      end else if (full) begin
        rsp.reply = RPL_FULL;
      end else begin
        rsp.reply      = RPL_RETRY;
        queue_nxt      = queue_push;
        queue_we       = 1'b1;
        meta_nxt.count = meta_q.count + CNT_W'(1);
        meta_we        = 1'b1;
      end
    end else begin
      rsp.reply = RPL_RETRY;
    end
    meta_we  = meta_we && cmd.commit;
    queue_we = queue_we && cmd.commit;
    used_we  = used_we && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_used_r <= '0;
    end else if (used_we) begin
      entry_used_r[lk] <= used_val;
    end
  end

  assign out_data = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && used) |-> (meta_q.count <= CNT_W'(QUEUE_DEPTH)))
    else $error("waiter count beyond queue depth");

  a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && rsp.reply == RPL_FULL) |-> (meta_q.count == CNT_W'(QUEUE_DEPTH)))
    else $error("queue full reported with free slots");

  a_retry_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && rsp.send_retry) |-> (req_r.req_type == REQ_RELEASE && used))
    else $error("retry sent for something other than a holder release");

endmodule

FILE: rtl/lock_manager_revoke_retry.sv
// ----------------------------------------------------------------------------
// Lock manager with revoke and retry
// Caching lock directory top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Each request word (acquire or release by a client on a lock) yields exactly
// one result word. A request first reads the lock's record and waiter row from
// the tables, then decides, writes both back and loads the result register;
// the next request is accepted in the cycle after that, since the lock tables
// have a single read/write port pair. A waiting result stalls the following
// request in its decision step. Lock-in-use flags all clear together at reset;
// there is no clearing pass and requests are accepted at once.
module lock_manager_revoke_retry (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lmrr_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lmrr_pkg::rsp_t   out_data
);

  import lmrr_pkg::*;

  ctrl_cmd_t cmd;

  lmrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lmrr_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: test/lmrr_checker.sv
// ----------------------------------------------------------------------------
// Lock directory checker
// Watches both channels of the lock manager, keeps its own copy of the lock
// directory, predicts the result word of every accepted request word and
// compares each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lmrr_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  lmrr_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  lmrr_pkg::rsp_t out_data,
  output int             fail_count,
  output int             owed
);

  import lmrr_pkg::*;

  logic                in_use    [NUM_LOCKS];
  logic [1:0]          mode_of   [NUM_LOCKS];
  logic [CLIENT_W-1:0] holder_of [NUM_LOCKS];
  logic                next_ok   [NUM_LOCKS];
  logic [CLIENT_W-1:0] next_of   [NUM_LOCKS];
  logic [CLIENT_W-1:0] waiting   [NUM_LOCKS][QUEUE_DEPTH];
  int unsigned         wait_cnt  [NUM_LOCKS];

  rsp_t owed_replies [$];

  initial begin
    fail_count = 0;
    owed       = 0;
  end

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Applies one request to the directory copy and returns the reply it earns.
  function automatic rsp_t directory_step(input req_t r);
    rsp_t                o;
    int                  lk;
    logic [CLIENT_W-1:0] c;
    logic [CLIENT_W-1:0] nx;
    logic                chosen;
    logic                known;
    logic [1:0]          m;
    o      = '0;
    lk     = int'(r.lock_id) % NUM_LOCKS;
    c      = r.client_id;
    chosen = in_use[lk] && next_ok[lk] && (next_of[lk] == c);
    known  = chosen;
    if (in_use[lk]) begin
      for (int i = 0; i < wait_cnt[lk] && i < QUEUE_DEPTH; i++) begin
        if (waiting[lk][i] == c) known = 1'b1;
      end
    end
    if (int'(c) >= NUM_CLIENTS) begin
      o.reply = RPL_RETRY;
    end else if (r.req_type == REQ_RELEASE) begin
      if (in_use[lk] && holder_of[lk] == c) begin
        if (wait_cnt[lk] > 0) begin
          // The oldest waiter is chosen and told to resend its acquire.
          nx = waiting[lk][0];
          for (int i = 1; i < QUEUE_DEPTH; i++) waiting[lk][i-1] = waiting[lk][i];
          wait_cnt[lk]--;
          mode_of[lk]    = MODE_RETRYING;
          next_ok[lk]    = 1'b1;
          next_of[lk]    = nx;
          o.send_retry   = 1'b1;
          o.retry_target = nx;
        end else begin
          in_use[lk] = 1'b0;
        end
      end
      o.reply = RPL_OK;
    end else if (!in_use[lk]) begin
      in_use[lk]    = 1'b1;
      mode_of[lk]   = MODE_LOCKED;
      holder_of[lk] = c;
      next_ok[lk]   = 1'b0;
      next_of[lk]   = '0;
      wait_cnt[lk]  = 0;
      o.reply       = RPL_OK;
    end else begin
      m = mode_of[lk];
      if (m == MODE_LOCKED || m == MODE_REVOKING) begin
        if (holder_of[lk] == c) begin
          o.reply = RPL_OK;
        end else if (known) begin
          o.reply         = RPL_RETRY;
          o.send_revoke   = 1'b1;
          o.revoke_target = holder_of[lk];
        end else if (wait_cnt[lk] >= QUEUE_DEPTH) begin
          o.reply = RPL_FULL;
        end else begin
          waiting[lk][wait_cnt[lk]] = c;
          wait_cnt[lk]++;
          o.reply = RPL_RETRY;
          if (m == MODE_LOCKED) begin
            mode_of[lk]     = MODE_REVOKING;
            o.send_revoke   = 1'b1;
            o.revoke_target = holder_of[lk];
          end
        end
      end else if (m == MODE_RETRYING) begin
        if (chosen) begin
          holder_of[lk] = c;
          if (wait_cnt[lk] > 0) begin
            mode_of[lk]     = MODE_REVOKING;
            o.send_revoke   = 1'b1;
            o.revoke_target = c;
          end else begin
            mode_of[lk] = MODE_LOCKED;
          end
          o.reply = RPL_OK;
        end else if (known) begin
          o.reply = RPL_RETRY;
        end else if (wait_cnt[lk] >= QUEUE_DEPTH) begin
          o.reply = RPL_FULL;
        end else begin
          waiting[lk][wait_cnt[lk]] = c;
          wait_cnt[lk]++;
          o.reply = RPL_RETRY;
        end
      end else begin
        o.reply = RPL_RETRY;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        in_use[i]    = 1'b0;
        mode_of[i]   = MODE_LOCKED;
        holder_of[i] = '0;
        next_ok[i]   = 1'b0;
        next_of[i]   = '0;
        wait_cnt[i]  = 0;
        for (int j = 0; j < QUEUE_DEPTH; j++) waiting[i][j] = '0;
      end
      owed_replies.delete();
    end else begin
      // A result word can never belong to a request accepted at this same edge.
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          check_field("reply", int'(want.reply), int'(out_data.reply));
          check_field("send_revoke", int'(want.send_revoke), int'(out_data.send_revoke));
          check_field("revoke_target", int'(want.revoke_target),
                      int'(out_data.revoke_target));
          check_field("send_retry", int'(want.send_retry), int'(out_data.send_retry));
          check_field("retry_target", int'(want.retry_target),
                      int'(out_data.retry_target));
        end
      end
      if (in_valid && in_ready) owed_replies = {owed_replies, directory_step(in_data)};
    end
    owed = owed_replies.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Lock manager testbench top
// Drives request words into the lock directory, first a directed walk through
// grant, revoke, retry, release and full-queue cases, then random traffic on
// small pools of hot locks, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import lmrr_pkg::*;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  int   fail_count;
  int   owed;
  logic squeeze_req = 1'b0;
  bit   no_gaps     = 1'b1;
  int   burst_left  = 0;

  always #5 clk = ~clk;

  lock_manager_revoke_retry dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lmrr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .owed       (owed)
  );

  function automatic req_t request_word(input logic rt, input int client, input int lock_no);
    req_t w;
    w.req_type  = rt;
    w.client_id = client[CLIENT_W-1:0];
    w.lock_id   = lock_no[LOCK_ID_W-1:0];
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic put_word(input req_t w);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: switches among its stall patterns at random, and once holds
  // off for a long stretch so that the block backs up into its input.
  initial begin
    rx_mode_e rx_mode;
    int       ticks;
    int       phase;
    int       held;
    bit       squeeze_done;
    rx_mode      = RX_OPEN;
    ticks        = 0;
    phase        = 0;
    held         = 0;
    squeeze_done = 1'b0;
    forever begin
      @(negedge clk);
      if (ticks == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        ticks   = $urandom_range(16, 96);
      end
      ticks--;
      phase++;
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        held++;
        if (held >= 300) squeeze_done = 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready <= (phase % 5 != 0);
          default:     out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #3000000;
    $display("lock_manager_revoke_retry: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] pool [8];
    int         sent;
    int         seg_len;
    int         pool_n;
    int         span;
    int         lo;
    int         rel_pct;
    int         lk;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk on lock 0: grant, revoke, repeated acquire, retry hand-over.
    put_word(request_word(REQ_ACQUIRE, 0, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 0, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 15, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 15, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 7, 8'h00));
    put_word(request_word(REQ_RELEASE, 3, 8'h00));
    put_word(request_word(REQ_RELEASE, 9, 8'hFF));
    put_word(request_word(REQ_RELEASE, 0, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 10, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 7, 8'h00));
    // The former holder releases again while the lock is being handed over.
    put_word(request_word(REQ_RELEASE, 0, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 15, 8'h00));
    put_word(request_word(REQ_ACQUIRE, 7, 8'h00));
    // Lock 255: grant, then a release with nobody waiting frees it.
    put_word(request_word(REQ_ACQUIRE, 1, 8'hFF));
    put_word(request_word(REQ_RELEASE, 1, 8'hFF));
    put_word(request_word(REQ_ACQUIRE, 2, 8'hFF));
    // Fill the waiting queue of another lock, then overflow it.
    put_word(request_word(REQ_ACQUIRE, 0, 8'h5A));
    for (int k = 1; k <= QUEUE_DEPTH; k++) put_word(request_word(REQ_ACQUIRE, k, 8'h5A));
    put_word(request_word(REQ_ACQUIRE, 1, 8'h5A));
    put_word(request_word(REQ_ACQUIRE, 9, 8'h5A));

    // Random traffic on small pools of hot locks so that queues build up.
    squeeze_req <= 1'b1;
    sent = 0;
    while (sent < 1200) begin
      pool_n = $urandom_range(1, 6);
      for (int k = 0; k < pool_n; k++) pool[k] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) pool[0] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      span    = ($urandom_range(0, 2) == 0) ? 16 : (($urandom_range(0, 1) != 0) ? 4 : 10);
      lo      = $urandom_range(0, 15);
      rel_pct = $urandom_range(15, 50);
      seg_len = $urandom_range(40, 120);
      repeat (seg_len) begin
        if (sent == 80) no_gaps = 1'b0;
        lk = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                          : int'(pool[$urandom_range(0, pool_n - 1)]);
        put_word(request_word($urandom_range(1, 100) <= rel_pct,
                              (lo + $urandom_range(0, span - 1)) % 16, lk));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (owed != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("lock_manager_revoke_retry: match");
    end else begin
      $display("lock_manager_revoke_retry: mismatch");
    end
    $finish;
  end

endmodule
